// ----- rtl/adi_pkg.sv -----
// Shared types, codes and constants of the arm/disarm interlock.
`default_nettype none
package adi_pkg;

	localparam int MAX_MONITORS_DEF = 16;
	localparam int TIMER_WIDTH_DEF  = 32;

	localparam int ACTION_W  = 3;
	localparam int ELAPSED_W = 16;
	localparam int INDEX_W   = 4;
	localparam int MODE_W    = 3;
	localparam int REPLY_W   = 3;
	localparam int MASK_W    = 16;
	localparam int COUNT_W   = 5;
	localparam int TIMEOUT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [COUNT_W-1:0]   COUNT_RESET   = '0;
	localparam logic [MASK_W-1:0]    KIND_RESET    = '0;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK       = 3'd0,
		ACT_ARM        = 3'd1,
		ACT_DISARM     = 3'd2,
		ACT_FULL_RPT   = 3'd3,
		ACT_SIMPLE_RPT = 3'd4
	} action_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_CANNOT    = 3'd0,
		MODE_DISARMED  = 3'd1,
		MODE_ARMING    = 3'd2,
		MODE_ARMED     = 3'd3,
		MODE_DISARMING = 3'd4
	} mode_t;

	typedef enum logic [REPLY_W-1:0] {
		REPLY_NONE      = 3'd0,
		REPLY_ARMING    = 3'd1,
		REPLY_WARN      = 3'd2,
		REPLY_DISARMING = 3'd3,
		REPLY_ACCEPT    = 3'd4,
		REPLY_REJECT    = 3'd5
	} reply_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT   = 2'd0,
		REG_KIND    = 2'd1,
		REG_TIMEOUT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_AGE,
		ST_DECIDE
	} ctl_state_t;

	typedef struct packed {
		action_t                action;
		logic [ELAPSED_W-1:0]   elapsed;
		logic [INDEX_W-1:0]     monitor_index;
		logic                   ready_req;
	} item_t;

	typedef struct packed {
		mode_t                  arm_state;
		reply_t                 reply;
		logic                   state_changed;
		logic [MASK_W-1:0]      never_heard_mask;
		logic [MASK_W-1:0]      not_ready_mask;
		logic [MASK_W-1:0]      stale_mask;
	} result_t;

	typedef struct packed {
		logic load;
		logic age;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic in_tick;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/adi_ifs.sv -----
// Request, result and configuration channel interfaces of the interlock.
`default_nettype none
interface adi_item_if;
	logic                               valid;
	logic                               ready;
	logic [adi_pkg::ACTION_W-1:0]       action;
	logic [adi_pkg::ELAPSED_W-1:0]      elapsed;
	logic [adi_pkg::INDEX_W-1:0]        monitor_index;
	logic                               ready_req;

	modport source (output valid, action, elapsed, monitor_index, ready_req, input ready);
	modport sink (input valid, action, elapsed, monitor_index, ready_req, output ready);
endinterface

interface adi_result_if;
	logic                               valid;
	logic                               ready;
	logic [adi_pkg::MODE_W-1:0]         arm_state;
	logic [adi_pkg::REPLY_W-1:0]        reply;
	logic                               state_changed;
	logic [adi_pkg::MASK_W-1:0]         never_heard_mask;
	logic [adi_pkg::MASK_W-1:0]         not_ready_mask;
	logic [adi_pkg::MASK_W-1:0]         stale_mask;

	modport source (output valid, arm_state, reply, state_changed, never_heard_mask,
		not_ready_mask, stale_mask, input ready);
	modport sink (input valid, arm_state, reply, state_changed, never_heard_mask,
		not_ready_mask, stale_mask, output ready);
endinterface

interface adi_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [adi_pkg::CFG_IDX_W-1:0]      index;
	logic [adi_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/adi_ctrl.sv -----
// Sequencing state machine: load, age counters on a tick, commit result.
`default_nettype none
module adi_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	output logic                     result_valid,
	input  wire logic                result_ready,
	input  wire adi_pkg::dp_status_t status,
	output adi_pkg::dp_cmd_t         cmd
);

	adi_pkg::ctl_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= adi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_free   = !out_valid_q || result_ready;
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			adi_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_tick ? adi_pkg::ST_AGE : adi_pkg::ST_DECIDE;
				end
			end
			adi_pkg::ST_AGE: begin
				cmd.age = 1'b1;
				state_d = adi_pkg::ST_DECIDE;
			end
			adi_pkg::ST_DECIDE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					item_ready = 1'b1;
					if (item_valid) begin
						cmd.load = 1'b1;
						state_d  = status.in_tick ? adi_pkg::ST_AGE : adi_pkg::ST_DECIDE;
					end else begin
						state_d = adi_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = adi_pkg::ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/adi_datapath.sv -----
// Monitor lanes, configuration registers, arm mode and result register.
`default_nettype none
module adi_datapath #(
	parameter int MAX_MONITORS = adi_pkg::MAX_MONITORS_DEF,
	parameter int TIMER_WIDTH  = adi_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire adi_pkg::item_t                   item,
	input  wire logic                             cfg_we,
	input  wire logic [adi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [adi_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire adi_pkg::dp_cmd_t                 cmd,
	output adi_pkg::dp_status_t                   status,
	output adi_pkg::result_t                      result
);

	localparam int SUM_W = ((TIMER_WIDTH > adi_pkg::ELAPSED_W) ?
		TIMER_WIDTH : adi_pkg::ELAPSED_W) + 1;
	localparam int CMP_W = (TIMER_WIDTH > adi_pkg::TIMEOUT_W) ?
		TIMER_WIDTH : adi_pkg::TIMEOUT_W;

	logic [adi_pkg::COUNT_W-1:0]   count_q;
	logic [adi_pkg::MASK_W-1:0]    kind_q;
	logic [adi_pkg::TIMEOUT_W-1:0] timeout_q;

	adi_pkg::item_t item_q;
	adi_pkg::mode_t mode_q, mode_d;
	adi_pkg::reply_t reply_d;
	logic changed_d;

	logic [MAX_MONITORS-1:0] heard_q, ready_q;
	logic [TIMER_WIDTH-1:0]  cnt_q [MAX_MONITORS];
	logic [TIMER_WIDTH-1:0]  aged   [MAX_MONITORS];

	logic [MAX_MONITORS-1:0] lane_used, never_l, notready_l, stale_l;
	logic [adi_pkg::MASK_W-1:0] never_m, notready_m, stale_m;

	logic is_tick, is_rpt, rpt_simple, idx_used, rpt_accept, all_ok;

	assign status.in_tick = (item.action == adi_pkg::ACT_TICK);

	// Per-monitor aging and classification, one lane per monitor.
	for (genvar g = 0; g < MAX_MONITORS; g++) begin : g_lane
		logic [SUM_W-1:0] sum;
		assign sum = SUM_W'(cnt_q[g]) + SUM_W'(item_q.elapsed);
		assign aged[g] = (|sum[SUM_W-1:TIMER_WIDTH]) ? '1 : sum[TIMER_WIDTH-1:0];
		assign lane_used[g]  = (32'(count_q) > 32'(g));
		assign never_l[g]    = lane_used[g] && !heard_q[g];
		assign notready_l[g] = lane_used[g] && heard_q[g] && !ready_q[g];
		assign stale_l[g]    = lane_used[g] && heard_q[g] && ready_q[g] &&
			(CMP_W'(cnt_q[g]) > CMP_W'(timeout_q));
	end

	for (genvar b = 0; b < adi_pkg::MASK_W; b++) begin : g_mask
		if (b < MAX_MONITORS) begin : g_on
			assign never_m[b]    = never_l[b];
			assign notready_m[b] = notready_l[b];
			assign stale_m[b]    = stale_l[b];
		end else begin : g_off
			assign never_m[b]    = 1'b0;
			assign notready_m[b] = 1'b0;
			assign stale_m[b]    = 1'b0;
		end
	end

	always_comb begin
		is_tick    = (item_q.action == adi_pkg::ACT_TICK);
		rpt_simple = (item_q.action == adi_pkg::ACT_SIMPLE_RPT);
		is_rpt     = rpt_simple || (item_q.action == adi_pkg::ACT_FULL_RPT);
		idx_used   = (adi_pkg::COUNT_W'(item_q.monitor_index) < count_q) &&
			(32'(item_q.monitor_index) < 32'(MAX_MONITORS));
		rpt_accept = is_rpt && idx_used && (kind_q[item_q.monitor_index] == rpt_simple);
		all_ok     = (count_q != '0) && !(|{never_l, notready_l, stale_l});

		mode_d    = mode_q;
		reply_d   = adi_pkg::REPLY_NONE;
		changed_d = 1'b0;
		case (item_q.action)
			adi_pkg::ACT_TICK: begin
				if (!all_ok) begin
					mode_d = adi_pkg::MODE_CANNOT;
				end else begin
					case (mode_q)
						adi_pkg::MODE_CANNOT:    mode_d = adi_pkg::MODE_DISARMED;
						adi_pkg::MODE_ARMING:    mode_d = adi_pkg::MODE_ARMED;
						adi_pkg::MODE_DISARMING: mode_d = adi_pkg::MODE_DISARMED;
						default:                 mode_d = mode_q;
					endcase
				end
				changed_d = (mode_d != mode_q);
			end
			adi_pkg::ACT_ARM: begin
				if (mode_q == adi_pkg::MODE_DISARMED) begin
					mode_d  = adi_pkg::MODE_ARMING;
					reply_d = adi_pkg::REPLY_ARMING;
				end else if (mode_q == adi_pkg::MODE_CANNOT) begin
					reply_d = adi_pkg::REPLY_WARN;
				end
			end
			adi_pkg::ACT_DISARM: begin
				if (mode_q == adi_pkg::MODE_ARMED) begin
					mode_d  = adi_pkg::MODE_DISARMING;
					reply_d = adi_pkg::REPLY_DISARMING;
				end
			end
			adi_pkg::ACT_FULL_RPT, adi_pkg::ACT_SIMPLE_RPT: begin
				reply_d = rpt_accept ? adi_pkg::REPLY_ACCEPT : adi_pkg::REPLY_REJECT;
			end
			default: begin
				reply_d = adi_pkg::REPLY_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= adi_pkg::COUNT_RESET;
			kind_q    <= adi_pkg::KIND_RESET;
			timeout_q <= adi_pkg::TIMEOUT_RESET;
			mode_q    <= adi_pkg::MODE_CANNOT;
			heard_q   <= '0;
			ready_q   <= '0;
			for (int i = 0; i < MAX_MONITORS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (adi_pkg::cfg_reg_t'(cfg_index))
					adi_pkg::REG_COUNT:   count_q   <= cfg_data[adi_pkg::COUNT_W-1:0];
					adi_pkg::REG_KIND:    kind_q    <= cfg_data[adi_pkg::MASK_W-1:0];
					adi_pkg::REG_TIMEOUT: timeout_q <= cfg_data[adi_pkg::TIMEOUT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				mode_q <= mode_d;
			end
			for (int i = 0; i < MAX_MONITORS; i++) begin
				if (cmd.age) begin
					cnt_q[i] <= aged[i];
				end else if (cmd.commit && rpt_accept &&
					(32'(item_q.monitor_index) == 32'(i))) begin
					heard_q[i] <= 1'b1;
					ready_q[i] <= item_q.ready_req;
					cnt_q[i]   <= '0;
				end
			end
		end
	end

	// Request and result payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.commit) begin
			result.arm_state        <= mode_d;
			result.reply            <= reply_d;
			result.state_changed    <= changed_d;
			result.never_heard_mask <= is_tick ? never_m : '0;
			result.not_ready_mask   <= is_tick ? notready_m : '0;
			result.stale_mask       <= is_tick ? stale_m : '0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/arm_disarm_interlock.sv -----
// Top level of the arm/disarm interlock: controller plus monitor datapath.
//
//   channel  | modport | payload                                        | accepted when
//   item     | sink    | action, elapsed, monitor_index, ready_req      | valid && ready
//   result   | source  | arm_state, reply, state_changed, three masks   | valid && ready
//   cfg      | sink    | index (0 count, 1 kind mask, 2 timeout), data  | valid && ready
//
// A tick ages all counters and then classifies and commits; any other request
// goes straight to classify and commit. Each request is one pass of the controller.
// The result register frees the request side: a new request is taken while a
// result waits, and a commit holds only while the result register is full.
// Reset clears mode, monitor flags and counters; cfg is always ready.
`default_nettype none
module arm_disarm_interlock #(
	parameter int MAX_MONITORS = adi_pkg::MAX_MONITORS_DEF,
	parameter int TIMER_WIDTH  = adi_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	adi_item_if.sink     item,
	adi_result_if.source result,
	adi_cfg_if.sink      cfg
);

	adi_pkg::dp_cmd_t    cmd;
	adi_pkg::dp_status_t status;
	adi_pkg::item_t      item_pl;
	adi_pkg::result_t    res_pl;

	assign item_pl.action        = adi_pkg::action_t'(item.action);
	assign item_pl.elapsed       = item.elapsed;
	assign item_pl.monitor_index = item.monitor_index;
	assign item_pl.ready_req     = item.ready_req;

	assign cfg.ready = 1'b1;

	adi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	adi_datapath #(
		.MAX_MONITORS (MAX_MONITORS),
		.TIMER_WIDTH  (TIMER_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_pl),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.status    (status),
		.result    (res_pl)
	);

	assign result.arm_state        = res_pl.arm_state;
	assign result.reply            = res_pl.reply;
	assign result.state_changed    = res_pl.state_changed;
	assign result.never_heard_mask = res_pl.never_heard_mask;
	assign result.not_ready_mask   = res_pl.not_ready_mask;
	assign result.stale_mask       = res_pl.stale_mask;

endmodule
`default_nettype wire

// ----- rtl/adi_checker.sv -----
// Port-level checks of the interlock and their bind to the top level.
`default_nettype none
module adi_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [adi_pkg::MODE_W-1:0]    arm_state,
	input wire logic [adi_pkg::REPLY_W-1:0]   reply,
	input wire logic                          state_changed,
	input wire logic [adi_pkg::MASK_W-1:0]    never_heard_mask,
	input wire logic [adi_pkg::MASK_W-1:0]    not_ready_mask,
	input wire logic [adi_pkg::MASK_W-1:0]    stale_mask
);

	logic [adi_pkg::MASK_W-1:0] any_fail;
	assign any_fail = never_heard_mask | not_ready_mask | stale_mask;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(arm_state) && $stable(reply)
			&& $stable(state_changed) && $stable(any_fail))
		else $error("result changed while stalled");

	a_cmd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reply != adi_pkg::REPLY_NONE) |-> !state_changed && (any_fail == '0))
		else $error("command or report result carries tick fields");

	a_fail_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (any_fail != '0) |-> (arm_state == adi_pkg::MODE_CANNOT))
		else $error("failing monitor without cannot-arm");

	a_arm_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reply == adi_pkg::REPLY_ARMING) |-> (arm_state == adi_pkg::MODE_ARMING))
		else $error("arming reply without arming mode");

endmodule

bind arm_disarm_interlock adi_checker u_adi_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.arm_state        (result.arm_state),
	.reply            (result.reply),
	.state_changed    (result.state_changed),
	.never_heard_mask (result.never_heard_mask),
	.not_ready_mask   (result.not_ready_mask),
	.stale_mask       (result.stale_mask)
);
`default_nettype wire

// ----- dv/arm_disarm_interlock_test.sv -----
// Testbench: directed and random requests checked against a local predictor.
`timescale 1ns / 1ps
module arm_disarm_interlock_test;
	import adi_pkg::*;

	localparam int ACTION_CODES = 1 << ACTION_W;
	localparam int MONITORS = MAX_MONITORS_DEF;

	logic clk;
	logic arst_n;

	adi_item_if   item_ch ();
	adi_result_if res_ch ();
	adi_cfg_if    cfg_ch ();

	arm_disarm_interlock dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// interlock state as the block should hold it
	logic [COUNT_W-1:0]   cnt_reg;
	logic [MASK_W-1:0]    kind_reg;
	logic [TIMEOUT_W-1:0] timeout_reg;
	mode_t                mode_q;
	logic [MONITORS-1:0]  heard_q;
	logic [MONITORS-1:0]  ready_q;
	logic [TIMEOUT_W-1:0] age_q [MONITORS];

	result_t pending_results [$];
	int      mismatches;
	bit      send_idle;
	bit      recv_idle;
	int      hold_req;

	always #4 clk = ~clk;

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(4, 40));
	endfunction

	function automatic int monitors_in_use();
		return (cnt_reg > MONITORS) ? MONITORS : int'(cnt_reg);
	endfunction

	function automatic result_t next_interlock_result(input logic [ACTION_W-1:0] act,
			input logic [ELAPSED_W-1:0] el, input logic [INDEX_W-1:0] idx, input logic rdy);
		result_t r;
		int n;
		logic [TIMEOUT_W:0] sum;
		mode_t prev;
		bit ok;
		bit simple;
		r = '0;
		r.reply = REPLY_NONE;
		n = monitors_in_use();
		case (act)
		ACT_TICK: begin
			prev = mode_q;
			ok = (n != 0);
			for (int i = 0; i < MONITORS; i++) begin
				sum = {1'b0, age_q[i]} + (TIMEOUT_W + 1)'(el);
				age_q[i] = sum[TIMEOUT_W] ? '1 : sum[TIMEOUT_W-1:0];
			end
			for (int i = 0; i < n; i++) begin
				if (!heard_q[i]) begin
					r.never_heard_mask[i] = 1'b1;
					ok = 0;
				end else if (!ready_q[i]) begin
					r.not_ready_mask[i] = 1'b1;
					ok = 0;
				end else if (age_q[i] > timeout_reg) begin
					r.stale_mask[i] = 1'b1;
					ok = 0;
				end
			end
			if (!ok)
				mode_q = MODE_CANNOT;
			else if (mode_q == MODE_CANNOT)
				mode_q = MODE_DISARMED;
			if (mode_q == MODE_ARMING)
				mode_q = MODE_ARMED;
			else if (mode_q == MODE_DISARMING)
				mode_q = MODE_DISARMED;
			r.state_changed = (mode_q != prev);
		end
		ACT_ARM: begin
			if (mode_q == MODE_DISARMED) begin
				mode_q = MODE_ARMING;
				r.reply = REPLY_ARMING;
			end else if (mode_q == MODE_CANNOT) begin
				r.reply = REPLY_WARN;
			end
		end
		ACT_DISARM: begin
			if (mode_q == MODE_ARMED) begin
				mode_q = MODE_DISARMING;
				r.reply = REPLY_DISARMING;
			end
		end
		ACT_FULL_RPT, ACT_SIMPLE_RPT: begin
			simple = (act == ACT_SIMPLE_RPT);
			if (int'(idx) >= n || kind_reg[idx] != simple) begin
				r.reply = REPLY_REJECT;
			end else begin
				heard_q[idx] = 1'b1;
				ready_q[idx] = rdy;
				age_q[idx] = '0;
				r.reply = REPLY_ACCEPT;
			end
		end
		default: ;
		endcase
		r.arm_state = mode_q;
		return r;
	endfunction

	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [ELAPSED_W-1:0] el,
			input logic [INDEX_W-1:0] idx, input logic rdy);
		int gap;
		gap = send_idle ? idle_gap() : 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.elapsed <= el;
		item_ch.monitor_index <= idx;
		item_ch.ready_req <= rdy;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_results = {pending_results, next_interlock_result(act, el, idx, rdy)};
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (r)
		REG_COUNT:   cnt_reg = value[COUNT_W-1:0];
		REG_KIND:    kind_reg = value[MASK_W-1:0];
		REG_TIMEOUT: timeout_reg = value[TIMEOUT_W-1:0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic report_bad(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endtask

	// registers at reset values: no monitors, so nothing can arm
	task automatic test_after_reset();
		send_request(ACT_TICK, '0, '0, 1'b0);
		send_request(ACT_ARM, '0, '0, 1'b0);
		send_request(ACT_DISARM, '0, '0, 1'b0);
		send_request(ACT_FULL_RPT, '0, '0, 1'b1);
		send_request(ACT_SIMPLE_RPT, '1, '1, 1'b1);
		for (int a = ACT_SIMPLE_RPT + 1; a < ACTION_CODES; a++)
			send_request(a[ACTION_W-1:0], '1, '1, 1'b1);
		wait_idle();
	endtask

	task automatic test_arm_cycle();
		write_reg(REG_COUNT, 32'd3);
		write_reg(REG_KIND, 32'h2);
		send_request(ACT_FULL_RPT, '0, 4'd0, 1'b1);
		send_request(ACT_SIMPLE_RPT, '0, 4'd0, 1'b1);
		send_request(ACT_SIMPLE_RPT, '0, 4'd1, 1'b1);
		send_request(ACT_FULL_RPT, '0, 4'd2, 1'b0);
		send_request(ACT_FULL_RPT, '0, 4'd3, 1'b1);
		send_request(ACT_SIMPLE_RPT, '0, 4'd15, 1'b1);
		send_request(ACT_TICK, 16'd10, '0, 1'b0);
		send_request(ACT_ARM, '0, '0, 1'b0);
		send_request(ACT_FULL_RPT, '0, 4'd2, 1'b1);
		send_request(ACT_TICK, '0, '0, 1'b0);
		send_request(ACT_DISARM, '0, '0, 1'b0);
		send_request(ACT_ARM, '0, '0, 1'b0);
		send_request(ACT_ARM, '0, '0, 1'b0);
		send_request(ACT_TICK, 16'd1, '0, 1'b0);
		send_request(ACT_ARM, '0, '0, 1'b0);
		send_request(ACT_DISARM, '0, '0, 1'b0);
		send_request(ACT_DISARM, '0, '0, 1'b0);
		send_request(ACT_TICK, 16'd1, '0, 1'b0);
		send_request(ACT_TICK, '1, '0, 1'b0);
		wait_idle();
	endtask

	// stale means strictly above the timeout
	task automatic test_timeout_edges();
		write_reg(REG_COUNT, 32'd1);
		write_reg(REG_KIND, 32'h0);
		write_reg(REG_TIMEOUT, 32'd5);
		send_request(ACT_FULL_RPT, '0, 4'd0, 1'b1);
		send_request(ACT_TICK, 16'd5, '0, 1'b0);
		send_request(ACT_TICK, 16'd1, '0, 1'b0);
		wait_idle();
		write_reg(REG_TIMEOUT, 32'd0);
		send_request(ACT_FULL_RPT, '0, 4'd0, 1'b1);
		send_request(ACT_TICK, 16'd0, '0, 1'b0);
		send_request(ACT_TICK, 16'd1, '0, 1'b0);
		wait_idle();
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		send_request(ACT_FULL_RPT, '0, 4'd0, 1'b1);
		send_request(ACT_TICK, '1, '0, 1'b0);
		wait_idle();
	endtask

	// counts above the monitor limit act as the limit
	task automatic test_count_above_max();
		write_reg(REG_COUNT, 32'd31);
		write_reg(REG_KIND, 32'hFFFF);
		write_reg(REG_TIMEOUT, 32'd1000);
		send_request(ACT_TICK, '0, '0, 1'b0);
		send_request(ACT_SIMPLE_RPT, '0, 4'd15, 1'b1);
		send_request(ACT_FULL_RPT, '0, 4'd15, 1'b1);
		send_request(ACT_TICK, 16'd3, '0, 1'b0);
		wait_idle();
		write_reg(REG_COUNT, 32'd16);
		send_request(ACT_TICK, 16'd3, '0, 1'b0);
		wait_idle();
	endtask

	// full-size ticks carry the age across a wide timeout
	task automatic test_long_ticks();
		write_reg(REG_COUNT, 32'd1);
		write_reg(REG_KIND, 32'h0);
		write_reg(REG_TIMEOUT, 32'h0003_0000);
		send_request(ACT_FULL_RPT, '0, 4'd0, 1'b1);
		send_idle = 0;
		recv_idle = 0;
		repeat (6)
			send_request(ACT_TICK, '1, '0, 1'b0);
		wait_idle();
		send_idle = 1;
		recv_idle = 1;
	endtask

	task automatic send_random_request();
		int r;
		int n;
		logic [ACTION_W-1:0] act;
		logic [ELAPSED_W-1:0] el;
		logic [INDEX_W-1:0] idx;
		logic rdy;
		bit simple;
		n = monitors_in_use();
		r = $urandom_range(0, 99);
		idx = INDEX_W'($urandom_range(0, MONITORS - 1));
		rdy = 1'($urandom_range(0, 1));
		el = ($urandom_range(0, 9) < 8) ? ELAPSED_W'($urandom_range(0, 200)) :
			ELAPSED_W'($urandom_range(0, 65535));
		if (r < 40) begin
			if (n != 0 && $urandom_range(0, 9) < 8)
				idx = INDEX_W'($urandom_range(0, n - 1));
			simple = ($urandom_range(0, 9) < 8) ? kind_reg[idx] : 1'($urandom_range(0, 1));
			act = simple ? ACT_SIMPLE_RPT : ACT_FULL_RPT;
			rdy = ($urandom_range(0, 9) != 0);
		end else if (r < 65) begin
			act = ACT_TICK;
		end else if (r < 80) begin
			act = ACT_ARM;
		end else if (r < 95) begin
			act = ACT_DISARM;
		end else begin
			act = ACTION_W'($urandom_range(ACT_SIMPLE_RPT + 1, ACTION_CODES - 1));
		end
		send_request(act, el, idx, rdy);
	endtask

	// result side holds off long enough for the request side to back up
	task automatic test_backpressure();
		write_reg(REG_COUNT, 32'd2);
		write_reg(REG_KIND, 32'h0);
		write_reg(REG_TIMEOUT, 32'd1000);
		send_idle = 0;
		hold_req = 120;
		repeat (24)
			send_random_request();
		wait_idle();
		send_idle = 1;
	endtask

	task automatic test_random_traffic();
		int r;
		for (int phase = 0; phase < 10; phase++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				write_reg(REG_COUNT, $urandom_range(1, 4));
			else if (r < 85)
				write_reg(REG_COUNT, $urandom_range(5, 16));
			else if (r < 93)
				write_reg(REG_COUNT, 32'd0);
			else
				write_reg(REG_COUNT, $urandom_range(17, 31));
			write_reg(REG_KIND, $urandom);
			r = $urandom_range(0, 99);
			if (r < 65)
				write_reg(REG_TIMEOUT, $urandom_range(150, 2500));
			else if (r < 75)
				write_reg(REG_TIMEOUT, 32'd0);
			else if (r < 85)
				write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
			else
				write_reg(REG_TIMEOUT, $urandom);
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			repeat (40)
				send_random_request();
			wait_idle();
		end
		send_idle = 1;
		recv_idle = 1;
	endtask

	initial begin : result_taker
		int n;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req != 0) begin
				n = hold_req;
				hold_req = 0;
				res_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = recv_idle ? idle_gap() : 0;
				if (n != 0) begin
					res_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end else begin
					res_ch.ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_bad("result with none pending", '0, 32'(res_ch.reply));
			end else begin
				want = pending_results.pop_front();
				if (res_ch.arm_state !== want.arm_state)
					report_bad("arm_state", 32'(want.arm_state), 32'(res_ch.arm_state));
				if (res_ch.reply !== want.reply)
					report_bad("reply", 32'(want.reply), 32'(res_ch.reply));
				if (res_ch.state_changed !== want.state_changed)
					report_bad("state_changed", 32'(want.state_changed),
						32'(res_ch.state_changed));
				if (res_ch.never_heard_mask !== want.never_heard_mask)
					report_bad("never_heard_mask", 32'(want.never_heard_mask),
						32'(res_ch.never_heard_mask));
				if (res_ch.not_ready_mask !== want.not_ready_mask)
					report_bad("not_ready_mask", 32'(want.not_ready_mask),
						32'(res_ch.not_ready_mask));
				if (res_ch.stale_mask !== want.stale_mask)
					report_bad("stale_mask", 32'(want.stale_mask), 32'(res_ch.stale_mask));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = '0;
		item_ch.elapsed = '0;
		item_ch.monitor_index = '0;
		item_ch.ready_req = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		cnt_reg = COUNT_RESET;
		kind_reg = KIND_RESET;
		timeout_reg = TIMEOUT_RESET;
		mode_q = MODE_CANNOT;
		heard_q = '0;
		ready_q = '0;
		foreach (age_q[i])
			age_q[i] = '0;
		mismatches = 0;
		send_idle = 1;
		recv_idle = 1;
		hold_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_after_reset();
		test_arm_cycle();
		test_timeout_edges();
		test_count_above_max();
		test_long_ticks();
		test_backpressure();
		test_random_traffic();

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
